// ----- rtl/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and reset values for the keypad code lock controller.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int MAX_CODE_KEYS_DEF = 8;
  localparam int ADDR_W            = 5;
  localparam int DATA_W            = 32;

  localparam logic [31:0] CODE_KEYS_RST   = 32'h0000_A321;
  localparam logic [3:0]  CODE_LENGTH_RST = 4'd4;
  localparam logic [11:0] BRIGHT_RST      = 12'd300;
  localparam logic [11:0] DARK_RST        = 12'd290;
  localparam logic [3:0]  ALERT_LIMIT_RST = 4'd3;

  typedef enum logic [2:0] {
    REG_CODE_KEYS   = 3'd0,
    REG_CODE_LENGTH = 3'd1,
    REG_BRIGHT      = 3'd2,
    REG_DARK        = 3'd3,
    REG_ALERT_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_ENTRY  = 2'd0,
    PH_BRIGHT = 2'd1,
    PH_DARK   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ECHO   = 3'd1,
    EV_OPEN   = 3'd2,
    EV_WRONG  = 3'd3,
    EV_ALERT  = 3'd4,
    EV_BRIGHT = 3'd5,
    EV_LOCKED = 3'd6
  } event_t;

  typedef struct packed {
    logic [31:0] code_keys;
    logic [3:0]  code_length;
    logic [11:0] bright_threshold;
    logic [11:0] dark_threshold;
    logic [3:0]  alert_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       door_open;
    logic [1:0] phase;
    logic [3:0] wrong_count;
  } result_t;

endpackage

// ----- rtl/kcl_regs.sv -----
// ----------------------------------------------------------------------------
// kcl_regs
// APB-style configuration registers of the code lock.
// ----------------------------------------------------------------------------
module kcl_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [kcl_pkg::DATA_W-1:0] pwdata,
  output logic [kcl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output kcl_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_keys        <= kcl_pkg::CODE_KEYS_RST;
      cfg.code_length      <= kcl_pkg::CODE_LENGTH_RST;
      cfg.bright_threshold <= kcl_pkg::BRIGHT_RST;
      cfg.dark_threshold   <= kcl_pkg::DARK_RST;
      cfg.alert_limit      <= kcl_pkg::ALERT_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        kcl_pkg::REG_CODE_KEYS:   cfg.code_keys        <= pwdata;
        kcl_pkg::REG_CODE_LENGTH: cfg.code_length      <= pwdata[3:0];
        kcl_pkg::REG_BRIGHT:      cfg.bright_threshold <= pwdata[11:0];
        kcl_pkg::REG_DARK:        cfg.dark_threshold   <= pwdata[11:0];
        kcl_pkg::REG_ALERT_LIMIT: cfg.alert_limit      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kcl_pkg::REG_CODE_KEYS:   prdata = cfg.code_keys;
      kcl_pkg::REG_CODE_LENGTH: prdata = {28'd0, cfg.code_length};
      kcl_pkg::REG_BRIGHT:      prdata = {20'd0, cfg.bright_threshold};
      kcl_pkg::REG_DARK:        prdata = {20'd0, cfg.dark_threshold};
      kcl_pkg::REG_ALERT_LIMIT: prdata = {28'd0, cfg.alert_limit};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- rtl/kcl_core.sv -----
// ----------------------------------------------------------------------------
// kcl_core
// Lock state and combinational step logic with a registered result.
// ----------------------------------------------------------------------------
module kcl_core #(
  parameter int MAX_CODE_KEYS = kcl_pkg::MAX_CODE_KEYS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             req_type,
  input  logic [3:0]       key_code,
  input  logic [11:0]      light_sample,
  input  kcl_pkg::cfg_t    cfg,
  output kcl_pkg::result_t res
);

  localparam int          CW      = (MAX_CODE_KEYS > 1) ? $clog2(MAX_CODE_KEYS) : 1;
  localparam logic [3:0]  MAX_LEN = 4'(MAX_CODE_KEYS);

  kcl_pkg::phase_t lock_phase, lock_phase_next;
  logic [CW-1:0]   keys_entered, keys_entered_next;
  logic            all_matched, all_matched_next;
  logic [3:0]      fail_tally, fail_tally_next;
  kcl_pkg::event_t ev;

  logic [3:0]  pos;
  logic [3:0]  expected;
  logic [CW:0] cnt_inc;
  logic [3:0]  eff_len;
  logic        judged;
  logic        matched;
  logic [3:0]  wrong_inc;
  logic        is_dark;
  logic        is_bright;

  assign pos      = 4'(keys_entered);
  assign expected = pos[3] ? 4'd0 : cfg.code_keys[{pos[2:0], 2'b00} +: 4];
  assign matched  = all_matched & (key_code == expected);
  assign cnt_inc  = {1'b0, keys_entered} + (CW+1)'(1);

  always_comb begin
    if (cfg.code_length == 4'd0) begin
      eff_len = 4'd1;
    end else if (cfg.code_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = cfg.code_length;
    end
  end

  assign judged    = 5'(cnt_inc) >= {1'b0, eff_len};
  assign wrong_inc = (fail_tally < cfg.alert_limit) ? fail_tally + 4'd1
                                                    : fail_tally;
  assign is_dark   = light_sample <= cfg.dark_threshold;
  assign is_bright = light_sample >= cfg.bright_threshold;

  always_comb begin
    lock_phase_next   = lock_phase;
    keys_entered_next = keys_entered;
    all_matched_next  = all_matched;
    fail_tally_next   = fail_tally;
    ev                = kcl_pkg::EV_NONE;
    case (lock_phase)
      kcl_pkg::PH_BRIGHT: begin
        if (req_type && is_bright) begin
          if (is_dark) begin
            lock_phase_next = kcl_pkg::PH_ENTRY;
            ev              = kcl_pkg::EV_LOCKED;
          end else begin
            lock_phase_next = kcl_pkg::PH_DARK;
            ev              = kcl_pkg::EV_BRIGHT;
          end
        end
      end
      kcl_pkg::PH_DARK: begin
        if (req_type && is_dark) begin
          lock_phase_next = kcl_pkg::PH_ENTRY;
          ev              = kcl_pkg::EV_LOCKED;
        end
      end
      default: begin
        lock_phase_next = kcl_pkg::PH_ENTRY;
        if (!req_type) begin
          if (!judged) begin
            keys_entered_next = cnt_inc[CW-1:0];
            all_matched_next  = matched;
            ev                = kcl_pkg::EV_ECHO;
          end else begin
            keys_entered_next = '0;
            all_matched_next  = 1'b1;
            if (matched) begin
              fail_tally_next = 4'd0;
              lock_phase_next = kcl_pkg::PH_BRIGHT;
              ev              = kcl_pkg::EV_OPEN;
            end else begin
              fail_tally_next = wrong_inc;
              ev = (wrong_inc >= cfg.alert_limit) ? kcl_pkg::EV_ALERT : kcl_pkg::EV_WRONG;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_phase   <= kcl_pkg::PH_ENTRY;
      keys_entered <= '0;
      all_matched  <= 1'b1;
      fail_tally   <= 4'd0;
    end else if (step) begin
      lock_phase   <= lock_phase_next;
      keys_entered <= keys_entered_next;
      all_matched  <= all_matched_next;
      fail_tally   <= fail_tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.event_res   <= ev;
      res.door_open   <= lock_phase_next != kcl_pkg::PH_ENTRY;
      res.phase       <= lock_phase_next;
      res.wrong_count <= fail_tally_next;
    end
  end

endmodule

// ----- rtl/keypad_code_lock_controller.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Code lock: key entry against a configured code, then light-driven relock.
// An accepted item's result enters the output register at the next clock edge.
// Throughput: one item per cycle; the single output register is refilled in the
// cycle it is taken, so input stalls only while a held result is stalled.
// Reset (synchronous, active high) clears the lock state, empties the output
// register and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller #(
  parameter int MAX_CODE_KEYS = kcl_pkg::MAX_CODE_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [3:0]                 key_code,
  input  logic [11:0]                light_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 event_res,
  output logic                       door_open,
  output logic [1:0]                 phase,
  output logic [3:0]                 wrong_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [kcl_pkg::DATA_W-1:0] pwdata,
  output logic [kcl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  kcl_pkg::cfg_t    cfg;
  kcl_pkg::result_t res;
  logic             accept;
  logic             out_valid_next;

  kcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcl_core #(
    .MAX_CODE_KEYS (MAX_CODE_KEYS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .req_type     (req_type),
    .key_code     (key_code),
    .light_sample (light_sample),
    .cfg          (cfg),
    .res          (res)
  );

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  assign event_res   = res.event_res;
  assign door_open   = res.door_open;
  assign phase       = res.phase;
  assign wrong_count = res.wrong_count;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keypad code lock controller. A short table of
// key presses, light samples and register writes walks the lock through code
// entry, opening, relocking and the odd cases, then random runs of mostly
// genuine unlock attempts and light sequences follow. Every result item is
// checked against its table row's expectation if given, else an in-bench
// model of the lock, with random idling on both sides of the item stream.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 42;
  localparam logic REQ_KEY       = 1'b0;
  localparam logic REQ_LIGHT     = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    kcl_pkg::reg_idx_t reg_sel;
    logic [31:0]       wdata;
    logic              rt;
    logic [3:0]        key;
    logic [11:0]       lvl;
    bit                has_exp;
    kcl_pkg::result_t  exp;
  } stim_row_t;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       req_type     = 1'b0;
  logic [3:0]                 key_code     = '0;
  logic [11:0]                light_sample = '0;
  logic                       out_stall    = 1'b0;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [kcl_pkg::ADDR_W-1:0] paddr        = '0;
  logic [kcl_pkg::DATA_W-1:0] pwdata       = '0;
  logic                       in_stall;
  logic                       out_valid;
  logic [2:0]                 event_res;
  logic                       door_open;
  logic [1:0]                 phase;
  logic [3:0]                 wrong_count;
  logic [kcl_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  kcl_pkg::cfg_t   lock_cfg;
  kcl_pkg::phase_t lock_st;
  logic [3:0]      keys_done;
  bit              match_so_far;
  logic [3:0]      wrong_tries;
  bit              attempt_ok;

  kcl_pkg::result_t pending_results[$];
  stim_row_t        dir_rows[$];
  int               errors     = 0;
  int               cycles     = 0;
  int               stall_left = 0;
  bit               tx_idle    = 1'b1;
  bit               rx_idle    = 1'b1;

  keypad_code_lock_controller dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .key_code     (key_code),
    .light_sample (light_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .door_open    (door_open),
    .phase        (phase),
    .wrong_count  (wrong_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (rst || !rx_idle) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    kcl_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result item with none expected, event_res %0d", $time, event_res);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", int'(want.event_res), int'(event_res));
        check_field("door_open", int'(want.door_open), int'(door_open));
        check_field("phase", int'(want.phase), int'(phase));
        check_field("wrong_count", int'(want.wrong_count), int'(wrong_count));
      end
    end
  end

  function automatic logic [3:0] code_nibble(logic [3:0] pos);
    if (pos >= 4'd8) return 4'd0;
    return lock_cfg.code_keys[int'(pos) * 4 +: 4];
  endfunction

  function automatic kcl_pkg::result_t next_lock_result(logic rt, logic [3:0] k,
                                                        logic [11:0] lv);
    kcl_pkg::result_t r;
    kcl_pkg::event_t  ev;
    int               len;
    ev = kcl_pkg::EV_NONE;
    if (lock_st == kcl_pkg::PH_ENTRY) begin
      if (rt == REQ_KEY) begin
        len = int'(lock_cfg.code_length);
        if (len == 0) len = 1;
        if (len > kcl_pkg::MAX_CODE_KEYS_DEF) len = kcl_pkg::MAX_CODE_KEYS_DEF;
        if (k != code_nibble(keys_done)) match_so_far = 1'b0;
        keys_done = keys_done + 4'd1;
        if (int'(keys_done) < len) begin
          ev = kcl_pkg::EV_ECHO;
        end else begin
          keys_done = '0;
          if (match_so_far) begin
            wrong_tries = '0;
            lock_st     = kcl_pkg::PH_BRIGHT;
            ev          = kcl_pkg::EV_OPEN;
          end else begin
            if (wrong_tries < lock_cfg.alert_limit) wrong_tries = wrong_tries + 4'd1;
            ev = (wrong_tries >= lock_cfg.alert_limit) ? kcl_pkg::EV_ALERT
                                                       : kcl_pkg::EV_WRONG;
          end
          match_so_far = 1'b1;
        end
      end
    end else if (rt == REQ_LIGHT) begin
      if (lock_st == kcl_pkg::PH_BRIGHT) begin
        if (lv >= lock_cfg.bright_threshold) begin
          if (lv <= lock_cfg.dark_threshold) begin
            lock_st = kcl_pkg::PH_ENTRY;
            ev      = kcl_pkg::EV_LOCKED;
          end else begin
            lock_st = kcl_pkg::PH_DARK;
            ev      = kcl_pkg::EV_BRIGHT;
          end
        end
      end else if (lv <= lock_cfg.dark_threshold) begin
        lock_st = kcl_pkg::PH_ENTRY;
        ev      = kcl_pkg::EV_LOCKED;
      end
    end
    r.event_res   = ev;
    r.door_open   = (lock_st != kcl_pkg::PH_ENTRY);
    r.phase       = lock_st;
    r.wrong_count = wrong_tries;
    return r;
  endfunction

  task automatic send_item(input logic rt, input logic [3:0] k, input logic [11:0] lv,
                           input bit use_typed, input kcl_pkg::result_t typed);
    kcl_pkg::result_t r;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= rt;
    key_code     <= k;
    light_sample <= lv;
    do @(posedge clk); while (in_stall);
    r = next_lock_result(rt, k, lv);
    pending_results.push_back(use_typed ? typed : r);
  endtask

  task automatic reg_write(input kcl_pkg::reg_idx_t r, input logic [31:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      kcl_pkg::REG_CODE_KEYS:   lock_cfg.code_keys        = v;
      kcl_pkg::REG_CODE_LENGTH: lock_cfg.code_length      = v[3:0];
      kcl_pkg::REG_BRIGHT:      lock_cfg.bright_threshold = v[11:0];
      kcl_pkg::REG_DARK:        lock_cfg.dark_threshold   = v[11:0];
      kcl_pkg::REG_ALERT_LIMIT: lock_cfg.alert_limit      = v[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] random_reg_value(kcl_pkg::reg_idx_t r);
    int pick;
    pick = $urandom_range(0, 5);
    case (r)
      kcl_pkg::REG_CODE_KEYS:
        return (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      kcl_pkg::REG_CODE_LENGTH:
        return (pick == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      kcl_pkg::REG_BRIGHT:
        return (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 : $urandom_range(0, 4095);
      kcl_pkg::REG_DARK:
        return (pick == 0) ? $urandom_range(0, 4095)
                           : $urandom_range(0, int'(lock_cfg.bright_threshold));
      kcl_pkg::REG_ALERT_LIMIT:
        return (pick == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      default:
        return '0;
    endcase
  endfunction

  // mostly genuine attempts and sensible light sequences, some noise
  function automatic void pick_item(output logic rt, output logic [3:0] k,
                                    output logic [11:0] lv);
    int   pick;
    logic [11:0] br, dk;
    br   = lock_cfg.bright_threshold;
    dk   = lock_cfg.dark_threshold;
    pick = $urandom_range(0, 9);
    rt   = REQ_LIGHT;
    k    = 4'($urandom_range(0, 15));
    lv   = 12'($urandom_range(0, 4095));
    if (lock_st == kcl_pkg::PH_ENTRY) begin
      if ($urandom_range(0, 11) != 0) begin
        rt = REQ_KEY;
        if (keys_done == 4'd0) attempt_ok = ($urandom_range(0, 3) != 0);
        if (attempt_ok) k = code_nibble(keys_done);
      end
    end else if (lock_st == kcl_pkg::PH_BRIGHT) begin
      if (pick == 0) rt = REQ_KEY;
      else if (pick < 4) lv = (br == 12'd0) ? 12'd0 : 12'($urandom_range(0, int'(br) - 1));
      else if (pick < 9) lv = 12'($urandom_range(int'(br), 4095));
    end else begin
      if (pick == 0) rt = REQ_KEY;
      else if (pick < 5)
        lv = (dk == 12'hFFF) ? 12'hFFF : 12'($urandom_range(int'(dk) + 1, 4095));
      else if (pick < 9) lv = 12'($urandom_range(0, int'(dk)));
    end
  endfunction

  function automatic stim_row_t item_row(logic rt, logic [3:0] k, logic [11:0] lv);
    stim_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_sel = kcl_pkg::REG_CODE_KEYS;
    row.wdata   = '0;
    row.rt      = rt;
    row.key     = k;
    row.lvl     = lv;
    row.has_exp = 1'b0;
    row.exp     = '0;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(kcl_pkg::reg_idx_t r, logic [31:0] v);
    stim_row_t row;
    row         = item_row(REQ_KEY, '0, '0);
    row.kind    = ROW_CFG;
    row.reg_sel = r;
    row.wdata   = v;
    return row;
  endfunction

  function automatic stim_row_t expect_row(stim_row_t row, kcl_pkg::event_t ev,
                                           kcl_pkg::phase_t ph, logic [3:0] wc);
    row.has_exp           = 1'b1;
    row.exp.event_res     = ev;
    row.exp.door_open     = (ph != kcl_pkg::PH_ENTRY);
    row.exp.phase         = ph;
    row.exp.wrong_count   = wc;
    return row;
  endfunction

  initial begin
    logic        rt;
    logic [3:0]  k;
    logic [11:0] lv;

    lock_cfg.code_keys        = kcl_pkg::CODE_KEYS_RST;
    lock_cfg.code_length      = kcl_pkg::CODE_LENGTH_RST;
    lock_cfg.bright_threshold = kcl_pkg::BRIGHT_RST;
    lock_cfg.dark_threshold   = kcl_pkg::DARK_RST;
    lock_cfg.alert_limit      = kcl_pkg::ALERT_LIMIT_RST;
    lock_st      = kcl_pkg::PH_ENTRY;
    keys_done    = '0;
    match_so_far = 1'b1;
    wrong_tries  = '0;
    attempt_ok   = 1'b1;

    // light ignored during entry, then the reset code opens the door
    dir_rows.push_back(expect_row(item_row(REQ_LIGHT, 4'd0, 12'd4095),
                                  kcl_pkg::EV_NONE, kcl_pkg::PH_ENTRY, 4'd0));
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'd1, 12'd0),
                                  kcl_pkg::EV_ECHO, kcl_pkg::PH_ENTRY, 4'd0));
    dir_rows.push_back(item_row(REQ_KEY, 4'd2, 12'd0));
    dir_rows.push_back(item_row(REQ_KEY, 4'd3, 12'd0));
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'hA, 12'd0),
                                  kcl_pkg::EV_OPEN, kcl_pkg::PH_BRIGHT, 4'd0));
    // key ignored while open, bright and dark edges
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'hF, 12'd0),
                                  kcl_pkg::EV_NONE, kcl_pkg::PH_BRIGHT, 4'd0));
    dir_rows.push_back(item_row(REQ_LIGHT, 4'd0, 12'd299));
    dir_rows.push_back(expect_row(item_row(REQ_LIGHT, 4'd0, 12'd300),
                                  kcl_pkg::EV_BRIGHT, kcl_pkg::PH_DARK, 4'd0));
    dir_rows.push_back(item_row(REQ_LIGHT, 4'd0, 12'd291));
    dir_rows.push_back(expect_row(item_row(REQ_LIGHT, 4'd0, 12'd290),
                                  kcl_pkg::EV_LOCKED, kcl_pkg::PH_ENTRY, 4'd0));
    // zero length acts as one key
    dir_rows.push_back(cfg_row(kcl_pkg::REG_CODE_LENGTH, 32'd0));
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'd0, 12'd0),
                                  kcl_pkg::EV_WRONG, kcl_pkg::PH_ENTRY, 4'd1));
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'd1, 12'd0),
                                  kcl_pkg::EV_OPEN, kcl_pkg::PH_BRIGHT, 4'd0));
    // bright sample that is also dark
    dir_rows.push_back(cfg_row(kcl_pkg::REG_BRIGHT, 32'd0));
    dir_rows.push_back(cfg_row(kcl_pkg::REG_DARK, 32'd4095));
    dir_rows.push_back(expect_row(item_row(REQ_LIGHT, 4'd0, 12'd0),
                                  kcl_pkg::EV_LOCKED, kcl_pkg::PH_ENTRY, 4'd0));
    // oversize length acts as eight keys, alert at a limit of one
    dir_rows.push_back(cfg_row(kcl_pkg::REG_CODE_KEYS, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(kcl_pkg::REG_CODE_LENGTH, 32'd15));
    dir_rows.push_back(cfg_row(kcl_pkg::REG_ALERT_LIMIT, 32'd1));
    repeat (7) dir_rows.push_back(item_row(REQ_KEY, 4'hF, 12'd0));
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'd0, 12'd0),
                                  kcl_pkg::EV_ALERT, kcl_pkg::PH_ENTRY, 4'd1));
    // length lowered part way through an attempt
    repeat (3) dir_rows.push_back(item_row(REQ_KEY, 4'hF, 12'd0));
    dir_rows.push_back(cfg_row(kcl_pkg::REG_CODE_LENGTH, 32'd2));
    dir_rows.push_back(item_row(REQ_KEY, 4'hF, 12'd0));
    dir_rows.push_back(expect_row(item_row(REQ_LIGHT, 4'd0, 12'd4095),
                                  kcl_pkg::EV_LOCKED, kcl_pkg::PH_ENTRY, 4'd0));
    // a limit of zero alerts on every wrong code
    dir_rows.push_back(cfg_row(kcl_pkg::REG_ALERT_LIMIT, 32'd0));
    dir_rows.push_back(item_row(REQ_KEY, 4'd0, 12'd0));
    dir_rows.push_back(expect_row(item_row(REQ_KEY, 4'd0, 12'd0),
                                  kcl_pkg::EV_ALERT, kcl_pkg::PH_ENTRY, 4'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        reg_write(dir_rows[i].reg_sel, dir_rows[i].wdata);
      else
        send_item(dir_rows[i].rt, dir_rows[i].key, dir_rows[i].lvl,
                  dir_rows[i].has_exp, dir_rows[i].exp);
    end

    for (int p = 0; p < PHASES; p++) begin
      for (int r = int'(kcl_pkg::REG_CODE_KEYS); r <= int'(kcl_pkg::REG_ALERT_LIMIT); r++)
      begin
        if ($urandom_range(0, 1) == 0)
          reg_write(kcl_pkg::reg_idx_t'(r), random_reg_value(kcl_pkg::reg_idx_t'(r)));
      end
      tx_idle = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_item(rt, k, lv);
        send_item(rt, k, lv, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kcl_pkg.sv
rtl/kcl_regs.sv
rtl/kcl_core.sv
rtl/keypad_code_lock_controller.sv
sim/tb.sv
